// ===== sv/tba_pkg.sv =====
package tba_pkg;

    // default sizing
    localparam int DEF_MEM_BLOCKS  = 1024;
    localparam int DEF_MAX_REQUEST = 255;

    localparam logic [9:0]  RESERVED_RESET = 10'd32;
    localparam logic [15:0] LAST_OWNER_ID  = 16'hFFFF;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_ALLOCATED     = 3'd0,
        STAT_TOO_FEW       = 3'd1,
        STAT_FREED         = 3'd2,
        STAT_NOT_FOUND     = 3'd3,
        STAT_IDS_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESTART,
        ST_SCAN,
        ST_POST
    } state_t;

    typedef enum logic [1:0] {
        MODE_ALLOC,
        MODE_FREE,
        MODE_RECOUNT
    } mode_t;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  request_blocks;
        logic [15:0] owner_to_free;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] owner_id;
        logic [9:0]  first_block;
        logic [9:0]  blocks_moved;
        logic [10:0] blocks_free;
    } result_t;

endpackage

// ===== sv/tba_tag_ram.sv =====
module tba_tag_ram import tba_pkg::*; #(
    parameter int DEPTH = DEF_MEM_BLOCKS,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tba_engine.sv =====
module tba_engine import tba_pkg::*; #(
    parameter int MEM_BLOCKS  = DEF_MEM_BLOCKS,
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [9:0]                    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  req_t                          in_req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output result_t                       res,
    output logic                          ram_we,
    output logic [$clog2(MEM_BLOCKS)-1:0] ram_waddr,
    output logic [15:0]                   ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(MEM_BLOCKS)-1:0] ram_raddr,
    input  logic [15:0]                   ram_rdata
);

    localparam int AW = $clog2(MEM_BLOCKS);
    localparam int CW = $clog2(MEM_BLOCKS + 1);
    localparam int LW = (CW > 10) ? CW : 10;
    localparam int SW = (CW > 11) ? CW : 11;

    state_t         state_reg, state_next;
    mode_t          mode_reg, mode_next;
    logic [9:0]     reserved_reg, reserved_next;
    logic [CW-1:0]  fc_reg, fc_next;
    logic [15:0]    next_id_reg, next_id_next;
    logic [CW-1:0]  rd_addr_reg, rd_addr_next;
    logic           p_vld_reg, p_vld_next;
    logic [AW-1:0]  p_addr_reg, p_addr_next;
    logic [CW-1:0]  moved_reg, moved_next;
    logic [CW-1:0]  zcnt_reg, zcnt_next;
    logic [AW-1:0]  first_reg, first_next;
    logic [7:0]     req_reg, req_next;
    logic [15:0]    who_reg, who_next;
    status_t        status_reg, status_next;
    logic [15:0]    id_reg, id_next;

    logic [LW-1:0]  res_ext, lim_ext;
    logic [CW-1:0]  res_lim;
    logic           alloc_done, issue, req_bad, hit;
    logic [SW-1:0]  moved_ext, fc_ext, first_ext;

    // reserved area clipped to the pool
    assign res_ext = LW'(reserved_reg);
    assign lim_ext = (res_ext < LW'(MEM_BLOCKS)) ? res_ext : LW'(MEM_BLOCKS);
    assign res_lim = lim_ext[CW-1:0];

    assign alloc_done = (SW'(moved_reg) == SW'(req_reg));
    assign req_bad    = (in_req.request_blocks == 8'd0)
                     || (SW'(in_req.request_blocks) > SW'(MAX_REQUEST))
                     || (SW'(fc_reg) < SW'(in_req.request_blocks));
    assign hit        = (ram_rdata == who_reg);

    assign moved_ext = SW'(moved_reg);
    assign fc_ext    = SW'(fc_reg);
    assign first_ext = SW'(first_reg);

    always_comb begin
        res.status       = status_reg;
        res.owner_id     = id_reg;
        res.first_block  = first_ext[9:0];
        res.blocks_moved = (moved_ext > SW'(1023)) ? 10'd1023 : moved_ext[9:0];
        res.blocks_free  = (fc_ext > SW'(2047)) ? 11'd2047 : fc_ext[10:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            mode_reg     <= MODE_RECOUNT;
            reserved_reg <= RESERVED_RESET;
            fc_reg       <= '0;
            next_id_reg  <= '0;
            rd_addr_reg  <= '0;
            p_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            reserved_reg <= reserved_next;
            fc_reg       <= fc_next;
            next_id_reg  <= next_id_next;
            rd_addr_reg  <= rd_addr_next;
            p_vld_reg    <= p_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_addr_reg <= p_addr_next;
        moved_reg  <= moved_next;
        zcnt_reg   <= zcnt_next;
        first_reg  <= first_next;
        req_reg    <= req_next;
        who_reg    <= who_next;
        status_reg <= status_next;
        id_reg     <= id_next;
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        reserved_next = reserved_reg;
        fc_next       = fc_reg;
        next_id_next  = next_id_reg;
        rd_addr_next  = rd_addr_reg;
        p_vld_next    = 1'b0;
        p_addr_next   = p_addr_reg;
        moved_next    = moved_reg;
        zcnt_next     = zcnt_reg;
        first_next    = first_reg;
        req_next      = req_reg;
        who_next      = who_reg;
        status_next   = status_reg;
        id_next       = id_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = p_addr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = rd_addr_reg[AW-1:0];
        issue         = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = rd_addr_reg[AW-1:0];
                rd_addr_next = rd_addr_reg + CW'(1);
                if (rd_addr_reg == CW'(MEM_BLOCKS - 1)) begin
                    fc_next    = CW'(MEM_BLOCKS) - res_lim;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                in_ready = !cfg_wr_en;
                if (in_valid && in_ready) begin
                    req_next    = in_req.request_blocks;
                    who_next    = in_req.owner_to_free;
                    moved_next  = '0;
                    zcnt_next   = '0;
                    first_next  = '0;
                    if (in_req.opcode == OP_ALLOC) begin
                        id_next = '0;
                        if (next_id_reg == LAST_OWNER_ID) begin
                            status_next = STAT_IDS_EXHAUSTED;
                            state_next  = ST_POST;
                        end else if (req_bad) begin
                            status_next = STAT_TOO_FEW;
                            state_next  = ST_POST;
                        end else begin
                            next_id_next = next_id_reg + 16'd1;
                            id_next      = next_id_reg + 16'd1;
                            mode_next    = MODE_ALLOC;
                            rd_addr_next = res_lim;
                            state_next   = ST_SCAN;
                        end
                    end else begin
                        id_next = in_req.owner_to_free;
                        if (in_req.owner_to_free == 16'd0) begin
                            status_next = STAT_NOT_FOUND;
                            state_next  = ST_POST;
                        end else begin
                            mode_next    = MODE_FREE;
                            rd_addr_next = '0;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end

            ST_RESTART: begin
                mode_next    = MODE_RECOUNT;
                rd_addr_next = res_lim;
                zcnt_next    = '0;
                moved_next   = '0;
                state_next   = ST_SCAN;
            end

            ST_SCAN: begin
                issue = (rd_addr_reg != CW'(MEM_BLOCKS))
                     && !((mode_reg == MODE_ALLOC) && alloc_done);
                if (issue) begin
                    ram_re       = 1'b1;
                    rd_addr_next = rd_addr_reg + CW'(1);
                    p_vld_next   = 1'b1;
                    p_addr_next  = rd_addr_reg[AW-1:0];
                end
                if (p_vld_reg) begin
                    case (mode_reg)
                        MODE_ALLOC: begin
                            if (!alloc_done && ram_rdata == 16'd0) begin
                                ram_we     = 1'b1;
                                ram_wdata  = id_reg;
                                moved_next = moved_reg + CW'(1);
                                if (moved_reg == '0) begin
                                    first_next = p_addr_reg;
                                end
                            end
                        end
                        MODE_FREE: begin
                            if (hit) begin
                                ram_we     = 1'b1;
                                moved_next = moved_reg + CW'(1);
                            end
                            if ((hit || ram_rdata == 16'd0) && CW'(p_addr_reg) >= res_lim) begin
                                zcnt_next = zcnt_reg + CW'(1);
                            end
                        end
                        default: begin
                            if (ram_rdata == 16'd0) begin
                                zcnt_next = zcnt_reg + CW'(1);
                            end
                        end
                    endcase
                end
                // end of scan
                if (mode_reg == MODE_ALLOC) begin
                    if (alloc_done) begin
                        p_vld_next  = 1'b0;
                        fc_next     = fc_reg - moved_reg;
                        status_next = STAT_ALLOCATED;
                        state_next  = ST_POST;
                    end
                end else if (!issue && !p_vld_reg) begin
                    if (mode_reg == MODE_FREE) begin
                        state_next = ST_POST;
                        if (moved_reg == '0) begin
                            status_next = STAT_NOT_FOUND;
                        end else begin
                            status_next = STAT_FREED;
                            fc_next     = zcnt_reg;
                        end
                    end else begin
                        fc_next    = zcnt_reg;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_POST: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new reserved count forces a recount; mid clearing pass the final
        // free count picks it up, on the last clearing cycle a recount follows
        if (cfg_wr_en) begin
            reserved_next = cfg_wr_data;
            if (state_reg != ST_CLEAR || state_next != ST_CLEAR) begin
                state_next = ST_RESTART;
                p_vld_next = 1'b0;
            end
        end
    end

    // read and write never hit the same tag in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("tag read and write collide");

    // allocation never writes a free tag
    a_alloc_tag_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_SCAN && mode_reg == MODE_ALLOC) |-> (ram_wdata != 16'd0))
        else $error("allocation wrote a zero tag");

    // free count stays within the pool
    a_fc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |-> (SW'(fc_reg) <= SW'(MEM_BLOCKS)))
        else $error("free count beyond pool");

    // a request is only taken with the read pipe empty
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE || $past(cfg_wr_en) || !p_vld_reg))
        else $error("request taken with reads in flight");

    // an allocated result always moved at least one block
    a_alloc_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && status_reg == STAT_ALLOCATED) |-> (moved_reg != '0))
        else $error("allocation reported with no blocks");

endmodule

// ===== sv/tagged_block_allocator_unit.sv =====
// Tagged block allocator: first-fit allocation of fixed-size blocks, each
// block carrying a 16-bit owner tag held in an on-chip tag RAM.
// Request channel (s_*): s_tuser = opcode (0 allocate, 1 free); s_tdata
// carries the block count and the owner to free. Result channel (m_*):
// m_tuser = status, m_tdata = owner id, first block, blocks moved, blocks
// free. One result per request, in request order.
// A request is served by a single tag scan through the RAM read port,
// one tag per cycle, then the result hand-off; m_tvalid rises in the
// same cycle as the engine can take the next request. Allocate scans
// from reserved_limit up to the block that completes the request,
// free scans all MEM_BLOCKS tags; refusals (ids exhausted, bad,
// oversized or unavailable count, owner 0) skip the scan.
// Writing cfg_wr_data (reserved count) recounts free blocks by a scan
// from the reserved limit to the pool top; s_tready stays low meanwhile.
// After reset a clearing pass zeroes all MEM_BLOCKS tags, one per cycle,
// with s_tready low; config writes still land.
// The result sits in an output register: a stalled m_tready does not stop
// the next request from being taken and scanned; its result then waits
// until the register drains.
module tagged_block_allocator_unit import tba_pkg::*; #(
    parameter int MEM_BLOCKS  = DEF_MEM_BLOCKS,
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
) (
    input  logic        aclk,
    input  logic        aresetn,
    // reserved block count, written when idle
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] request_blocks, [23:8] owner_to_free
    input  logic        s_tuser,   // [0] opcode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] owner_id, [25:16] first_block,
                                   // [35:26] blocks_moved, [46:36] blocks_free, [47] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int AW = $clog2(MEM_BLOCKS);

    req_t          req;
    result_t       res;
    logic          res_valid, res_ready;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          m_valid_reg, m_valid_next;
    result_t       m_data_reg, m_data_next;

    assign req.opcode         = s_tuser;
    assign req.request_blocks = s_tdata[7:0];
    assign req.owner_to_free  = s_tdata[23:8];

    tba_engine #(
        .MEM_BLOCKS  (MEM_BLOCKS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    tba_tag_ram #(
        .DEPTH (MEM_BLOCKS),
        .WIDTH (16)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: loads when empty or draining
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.status;
    assign m_tdata  = {1'b0, m_data_reg.blocks_free, m_data_reg.blocks_moved,
                       m_data_reg.first_block, m_data_reg.owner_id};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Block allocator bench: a directed table, then random phases at several
// reserved counts, each result checked against its typed row or a mirror of the tag RAM.
module tb_top;
    import tba_pkg::*;

    localparam int POOL       = DEF_MEM_BLOCKS;
    localparam int MAX_REQ    = DEF_MAX_REQUEST;
    localparam int PHASES     = 7;
    localparam int PHASE_REQS = 80;
    // worst case: every request a full scan plus both stalls, plus recounts
    // and the clearing pass after reset, then taken nearly five times over
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic    opcode;
        logic [7:0]  count;
        logic [15:0] owner;
        bit      typed;     // expected result given in the row itself
        result_t want;
    } row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [9:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    // mirror of the allocator state
    logic [15:0] owner_tags [POOL];
    int          free_blocks;
    int          last_owner;
    int          reserved;
    int          live_owners [$];   // ids that still hold blocks

    result_t     owed_results [$];
    row_t        dir_rows [$];
    int          errors;
    int          cycles;
    int          stall_left;
    bit          quiet;              // no idling on either side

    tagged_block_allocator_unit #(
        .MEM_BLOCKS (POOL),
        .MAX_REQUEST(MAX_REQ)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Mirror of the allocator
    // ---------------------------------------------------------------

    // first block that may be handed out
    function automatic int alloc_base();
        return (reserved < POOL) ? reserved : POOL;
    endfunction

    // free count is the number of zero tags at or above the reserved area
    function automatic void recount_free();
        int i;
        free_blocks = 0;
        for (i = alloc_base(); i < POOL; i++) begin
            if (owner_tags[i] == 16'd0) free_blocks++;
        end
    endfunction

    function automatic result_t apply_request(req_t r);
        result_t res;
        int      i;
        int      moved;
        res   = '0;
        moved = 0;
        if (r.opcode == OP_ALLOC) begin
            // id exhaustion wins over the block count check
            if (last_owner >= int'(LAST_OWNER_ID)) begin
                res.status = STAT_IDS_EXHAUSTED;
            end else if (r.request_blocks == 0 || int'(r.request_blocks) > MAX_REQ ||
                         free_blocks < int'(r.request_blocks)) begin
                res.status = STAT_TOO_FEW;
            end else begin
                last_owner++;
                res.owner_id = last_owner[15:0];
                // first fit, ascending from the end of the reserved area
                for (i = alloc_base(); i < POOL && moved < int'(r.request_blocks); i++) begin
                    if (owner_tags[i] == 16'd0) begin
                        if (moved == 0) res.first_block = i[9:0];
                        owner_tags[i] = last_owner[15:0];
                        moved++;
                    end
                end
                free_blocks -= moved;
                res.status = STAT_ALLOCATED;
                live_owners.push_back(last_owner);
            end
        end else begin
            res.owner_id = r.owner_to_free;
            // owner zero never matches; blocks below the reserved area are
            // cleared too and fall back to reserved
            if (r.owner_to_free != 16'd0) begin
                for (i = 0; i < POOL; i++) begin
                    if (owner_tags[i] == r.owner_to_free) begin
                        owner_tags[i] = 16'd0;
                        moved++;
                    end
                end
            end
            if (moved == 0) begin
                res.status = STAT_NOT_FOUND;
            end else begin
                recount_free();
                res.status = STAT_FREED;
                for (i = 0; i < live_owners.size(); i++) begin
                    if (live_owners[i] == int'(r.owner_to_free)) begin
                        live_owners.delete(i);
                        break;
                    end
                end
            end
        end
        res.blocks_moved = (moved > 1023) ? 10'd1023 : moved[9:0];
        res.blocks_free  = (free_blocks > 2047) ? 11'd2047 : free_blocks[10:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic row_t mk_row(logic op, logic [7:0] count, logic [15:0] owner, bit typed,
                                    status_t st, logic [15:0] id, logic [9:0] first,
                                    logic [9:0] moved, logic [10:0] left);
        row_t row;
        row.opcode = op;
        row.count  = count;
        row.owner  = owner;
        row.typed  = typed;
        row.want   = '{status: st, owner_id: id, first_block: first,
                       blocks_moved: moved, blocks_free: left};
        return row;
    endfunction

    // Mostly well-formed traffic: allocations of small runs and frees of
    // live owners; some noise (unknown owners, owner zero, zero counts).
    function automatic req_t pick_request();
        req_t r;
        int   k;
        r.opcode         = OP_ALLOC;
        r.request_blocks = 8'($urandom_range(0, 255));
        r.owner_to_free  = 16'($urandom_range(0, 65535));
        k = $urandom_range(0, 99);
        if (k < 8) begin
            case ($urandom_range(0, 2))
                0: r.opcode = OP_FREE;
                1: begin
                    r.opcode        = OP_FREE;
                    r.owner_to_free = 16'd0;
                end
                default: r.request_blocks = 8'd0;
            endcase
        end else if (live_owners.size() == 0 ||
                     (k < 52 && !(free_blocks < 40 && $urandom_range(0, 1) == 1))) begin
            r.request_blocks = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 40));
        end else begin
            r.opcode = OP_FREE;
            if (k >= 95 && last_owner > 0)
                r.owner_to_free = 16'($urandom_range(1, last_owner));   // may be stale
            else
                r.owner_to_free = 16'(live_owners[$urandom_range(0, live_owners.size() - 1)]);
        end
        return r;
    endfunction

    // Called at a rising edge. Holds the request until it is taken, then
    // records what the allocator must answer.
    task automatic send_request(req_t r, bit typed, result_t want);
        result_t got;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.opcode;
        s_tdata  <= {r.owner_to_free, r.request_blocks};
        do @(posedge aclk); while (!s_tready);
        got = apply_request(r);
        owed_results.push_back(typed ? want : got);
    endtask

    // stop sending until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_results.size() != 0);
    endtask

    // reserved count is only changed while the allocator is idle
    task automatic write_reserved(logic [9:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        reserved = int'(value);
        recount_free();
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, then compare with the oldest request
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("status",       int'(want.status),       int'(m_tuser));
                check_field("owner_id",     int'(want.owner_id),     int'(m_tdata[15:0]));
                check_field("first_block",  int'(want.first_block),  int'(m_tdata[25:16]));
                check_field("blocks_moved", int'(want.blocks_moved), int'(m_tdata[35:26]));
                check_field("blocks_free",  int'(want.blocks_free),  int'(m_tdata[46:36]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[tagged_block_allocator_unit] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        int      n;
        int      p;
        int      rsv_plan [PHASES];
        req_t    r;
        result_t none;

        errors     = 0;
        cycles     = 0;
        stall_left = 0;
        quiet      = 1'b0;
        none       = '0;
        for (n = 0; n < POOL; n++) owner_tags[n] = 16'd0;
        reserved   = int'(RESERVED_RESET);
        last_owner = 0;
        recount_free();

        // Directed table at the reset reserved count (32, so 992 free).
        // Typed rows are read straight off the allocation rules; the rest
        // go through the mirror.
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd1,   16'd0,     1'b1, STAT_ALLOCATED, 16'd1,     10'd32,  10'd1,   11'd991));
        // zero count is refused without using an id
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd0,   16'hFFFF,  1'b1, STAT_TOO_FEW,   16'd0,     10'd0,   10'd0,   11'd991));
        // owner zero never matches
        dir_rows.push_back(mk_row(OP_FREE,  8'hFF,  16'd0,     1'b1, STAT_NOT_FOUND, 16'd0,     10'd0,   10'd0,   11'd991));
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'hFFFF,  1'b1, STAT_NOT_FOUND, 16'hFFFF,  10'd0,   10'd0,   11'd991));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd255, 16'd0,     1'b1, STAT_ALLOCATED, 16'd2,     10'd33,  10'd255, 11'd736));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd255, 16'd0,     1'b1, STAT_ALLOCATED, 16'd3,     10'd288, 10'd255, 11'd481));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd255, 16'd0,     1'b1, STAT_ALLOCATED, 16'd4,     10'd543, 10'd255, 11'd226));
        // too few blocks left
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd255, 16'd0,     1'b1, STAT_TOO_FEW,   16'd0,     10'd0,   10'd0,   11'd226));
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'd1,     1'b1, STAT_FREED,     16'd1,     10'd0,   10'd1,   11'd227));
        // fills the hole at 32 and then the tail of the pool
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd227, 16'd0,     1'b1, STAT_ALLOCATED, 16'd5,     10'd32,  10'd227, 11'd0));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd1,   16'd0,     1'b1, STAT_TOO_FEW,   16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'd3,     1'b1, STAT_FREED,     16'd3,     10'd0,   10'd255, 11'd255));
        // second free of the same owner finds nothing
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'd3,     1'b1, STAT_NOT_FOUND, 16'd3,     10'd0,   10'd0,   11'd255));
        // exact fit
        dir_rows.push_back(mk_row(OP_ALLOC, 8'd255, 16'h5A5A,  1'b1, STAT_ALLOCATED, 16'd6,     10'd288, 10'd255, 11'd0));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'h80,  16'hAAAA,  1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'h55,  16'hAAAA,  1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'hAA,  16'd2,     1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'h7F,  16'h5555,  1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'h01,  16'h5555,  1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'd4,     1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'd5,     1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_FREE,  8'd0,   16'd6,     1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));
        dir_rows.push_back(mk_row(OP_ALLOC, 8'h55,  16'hA5A5,  1'b0, STAT_ALLOCATED, 16'd0,     10'd0,   10'd0,   11'd0));

        // Reserved counts per phase: zero first so low blocks get owners,
        // then a larger count strands them (freed blocks turn reserved),
        // the top extreme, 1000, a random one, zero again, and back to the reset value.
        rsv_plan = '{0, 200, 1023, 1000, 5, 0, 32};
        rsv_plan[4] = $urandom_range(1, 1022);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // s_tready stays low through the clearing pass; the handshake waits
        foreach (dir_rows[i]) begin
            r.opcode         = dir_rows[i].opcode;
            r.request_blocks = dir_rows[i].count;
            r.owner_to_free  = dir_rows[i].owner;
            send_request(r, dir_rows[i].typed, dir_rows[i].want);
        end

        for (p = 0; p < PHASES; p++) begin
            write_reserved(rsv_plan[p][9:0]);
            quiet = (p == PHASES - 1);
            for (n = 0; n < PHASE_REQS; n++) begin
                if (n == PHASE_REQS / 2 && p == 1) drain_results();
                send_request(pick_request(), 1'b0, none);
            end
        end

        drain_results();
        repeat (POOL + 16) @(posedge aclk);

        if (errors == 0) begin
            $display("[tagged_block_allocator_unit] OK");
        end else begin
            $display("[tagged_block_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== tagged_block_allocator_unit.f =====
sv/tba_pkg.sv
sv/tba_tag_ram.sv
sv/tba_engine.sv
sv/tagged_block_allocator_unit.sv
verif/tb_top.sv
